// ===== rtl/core/sacl_pkg.sv =====
// shared types and constants of the set-associative lru cache lookup core
package sacl_pkg;

  localparam int KIND_W     = 2;
  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int SET_CFG_W  = 4;
  localparam int OFF_CFG_W  = 5;
  localparam int WAYS_CFG_W = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_FETCH  = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_STORE  = 2'd2,
    KIND_MODIFY = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS  = 2'd0,
    CFG_OFF_BITS  = 2'd1,
    CFG_WAYS      = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic hit;
    logic evict;
  } lookup_stat_t;

endpackage

// ===== rtl/core/sacl_row_update.sv =====
// tag compare, victim choice and lru age update for one set row
module sacl_row_update import sacl_pkg::*; #(
  parameter int MAX_WAYS = 8,
  parameter int TAGW     = 30,
  parameter int AGEW     = 3,
  parameter int WCW      = 4
) (
  input  logic [WCW-1:0]                 ways_i,
  input  logic [TAGW-1:0]                tag_i,
  input  logic [MAX_WAYS-1:0]            vld_i,
  input  logic [MAX_WAYS-1:0][TAGW-1:0]  tag_row_i,
  input  logic [MAX_WAYS-1:0][AGEW-1:0]  age_i,
  output logic [MAX_WAYS-1:0]            vld_o,
  output logic [MAX_WAYS-1:0][TAGW-1:0]  tag_row_o,
  output logic [MAX_WAYS-1:0][AGEW-1:0]  age_o,
  output lookup_stat_t                   stat_o
);

  localparam int WIW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic [MAX_WAYS-1:0] used;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] inv_vec;
  logic [WIW-1:0]      hit_way;
  logic [WIW-1:0]      inv_way;
  logic [WIW-1:0]      vic_way;
  logic [WIW-1:0]      way;
  logic [AGEW-1:0]     old_age;
  logic                hit;
  logic                any_inv;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      used[w]    = WCW'(w) < ways_i;
      hit_vec[w] = used[w] && vld_i[w] && (tag_row_i[w] == tag_i);
      inv_vec[w] = used[w] && !vld_i[w];
    end
    hit     = |hit_vec;
    any_inv = |inv_vec;
    hit_way = '0;
    inv_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WIW'(w);
      if (inv_vec[w]) inv_way = WIW'(w);
    end
    // first used way with the lowest age
    vic_way = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (used[w] && (age_i[w] < age_i[vic_way])) vic_way = WIW'(w);
    end
    if (hit) begin
      way = hit_way;
    end else if (any_inv) begin
      way = inv_way;
    end else begin
      way = vic_way;
    end
    old_age   = age_i[way];
    vld_o     = vld_i;
    tag_row_o = tag_row_i;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (used[w] && vld_i[w] && (age_i[w] > old_age)) begin
        age_o[w] = age_i[w] - AGEW'(1);
      end else begin
        age_o[w] = age_i[w];
      end
    end
    age_o[way] = AGEW'(ways_i - WCW'(1));
    if (!hit) begin
      vld_o[way]     = 1'b1;
      tag_row_o[way] = tag_i;
    end
    stat_o.hit   = hit;
    stat_o.evict = !hit && !any_inv;
  end

endmodule

// ===== rtl/core/set_assoc_lru_cache_lookup_core.sv =====
// a load or store gives one result, registered after its set row is updated
// a modify gives two, the second on its own forwarded row; a fetch gives none
// a new lookup is taken only after the last one, both passes of a modify, is done,
// as set by the read-modify-write of one set row in the single-port tag/age memory
// reset: config registers to 1, totals to zero, per-set valid flags cleared at once;
// the row memory itself is not cleared
module set_assoc_lru_cache_lookup_core import sacl_pkg::*; #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [ADDR_W-1:0]     address_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  hit_o,
  output logic                  miss_o,
  output logic                  eviction_o,
  output logic                  last_o,
  output logic [CNT_W-1:0]      hit_total_o,
  output logic [CNT_W-1:0]      miss_total_o,
  output logic [CNT_W-1:0]      eviction_total_o
);

  localparam int SETS   = 1 << MAX_SET_BITS;
  localparam int SETW   = MAX_SET_BITS;
  localparam int TAGW   = ADDRESS_BITS - 2;
  localparam int AGEW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCW    = $clog2(MAX_WAYS + 1);
  localparam int SBW    = $clog2(MAX_SET_BITS + 1);
  localparam int SHW    = (ADDRESS_BITS > ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int SHIFTW = $clog2(MAX_SET_BITS + 32);

  typedef struct packed {
    logic [MAX_WAYS-1:0]           vld;
    logic [MAX_WAYS-1:0][TAGW-1:0] tag;
    logic [MAX_WAYS-1:0][AGEW-1:0] age;
  } row_t;

  typedef enum logic {
    S_IDLE,
    S_LOOK
  } state_e;

  state_e                 state_q;
  logic [SET_CFG_W-1:0]   set_cfg_q;
  logic [OFF_CFG_W-1:0]   off_cfg_q;
  logic [WAYS_CFG_W-1:0]  ways_cfg_q;

  logic [SBW-1:0]         s_eff;
  logic [OFF_CFG_W-1:0]   b_eff;
  logic [WCW-1:0]         ways_eff;
  logic [SHIFTW-1:0]      shamt;
  logic [SHW-1:0]         addr_ext;
  logic [SETW-1:0]        set_idx;
  logic [TAGW-1:0]        tag_in;

  logic [SETW-1:0]        set_q;
  logic [TAGW-1:0]        tag_q;
  logic                   modify_q;
  logic                   fwd_q;
  row_t                   fwd_row_q;

  row_t                   mem_q [SETS];
  row_t                   rd_row_q;
  logic                   rd_vld_q;
  logic [SETS-1:0]        row_vld_q;

  row_t                   cur_row;
  row_t                   new_row;
  lookup_stat_t           st;
  logic                   rd_en;
  logic                   lk_fire;

  logic                   out_valid_q;
  logic                   hit_q;
  logic                   evict_q;
  logic                   last_q;
  logic [CNT_W-1:0]       hit_cnt_q;
  logic [CNT_W-1:0]       miss_cnt_q;
  logic [CNT_W-1:0]       evict_cnt_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_cfg_q  <= SET_CFG_W'(1);
      off_cfg_q  <= OFF_CFG_W'(1);
      ways_cfg_q <= WAYS_CFG_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SET_BITS: set_cfg_q  <= SET_CFG_W'(cfg_data_i);
        CFG_OFF_BITS: off_cfg_q  <= cfg_data_i;
        CFG_WAYS:     ways_cfg_q <= WAYS_CFG_W'(cfg_data_i);
        default:      ;
      endcase
    end
  end

  always_comb begin
    if (set_cfg_q == '0) begin
      s_eff = SBW'(1);
    end else if (32'(set_cfg_q) > MAX_SET_BITS) begin
      s_eff = SBW'(MAX_SET_BITS);
    end else begin
      s_eff = SBW'(set_cfg_q);
    end
    if (ways_cfg_q == '0) begin
      ways_eff = WCW'(1);
    end else if (32'(ways_cfg_q) > MAX_WAYS) begin
      ways_eff = WCW'(MAX_WAYS);
    end else begin
      ways_eff = WCW'(ways_cfg_q);
    end
    b_eff = (off_cfg_q == '0) ? OFF_CFG_W'(1) : off_cfg_q;
  end

  // address split
  assign addr_ext = SHW'(address_i);
  assign shamt    = SHIFTW'(s_eff) + SHIFTW'(b_eff);
  assign set_idx  = SETW'(address_i >> b_eff) & ~({SETW{1'b1}} << s_eff);
  assign tag_in   = (32'(shamt) < ADDRESS_BITS) ? TAGW'(addr_ext >> shamt) : '0;

  // handshakes
  assign in_ready_o = (state_q == S_IDLE);
  assign rd_en      = in_valid_i && in_ready_o && (kind_e'(kind_i) != KIND_FETCH);
  assign lk_fire    = (state_q == S_LOOK) && (!out_valid_q || out_ready_i);

  // set row memory
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_row_q <= mem_q[set_idx];
    end
    if (lk_fire) begin
      mem_q[set_q] <= new_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_q <= row_vld_q[set_idx];
      end
      if (lk_fire) begin
        row_vld_q[set_q] <= 1'b1;
      end
    end
  end

  // a set never written reads as all lines invalid with age zero
  always_comb begin
    if (fwd_q) begin
      cur_row = fwd_row_q;
    end else begin
      cur_row.tag = rd_row_q.tag;
      cur_row.vld = rd_vld_q ? rd_row_q.vld : '0;
      cur_row.age = rd_vld_q ? rd_row_q.age : '0;
    end
  end

  sacl_row_update #(
    .MAX_WAYS (MAX_WAYS),
    .TAGW     (TAGW),
    .AGEW     (AGEW),
    .WCW      (WCW)
  ) u_row_update (
    .ways_i    (ways_eff),
    .tag_i     (tag_q),
    .vld_i     (cur_row.vld),
    .tag_row_i (cur_row.tag),
    .age_i     (cur_row.age),
    .vld_o     (new_row.vld),
    .tag_row_o (new_row.tag),
    .age_o     (new_row.age),
    .stat_o    (st)
  );

  // control and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      set_q       <= '0;
      tag_q       <= '0;
      modify_q    <= 1'b0;
      fwd_q       <= 1'b0;
      fwd_row_q   <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      evict_q     <= 1'b0;
      last_q      <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !lk_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (rd_en) begin
            set_q    <= set_idx;
            tag_q    <= tag_in;
            modify_q <= (kind_e'(kind_i) == KIND_MODIFY);
            fwd_q    <= 1'b0;
            state_q  <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (lk_fire) begin
            out_valid_q <= 1'b1;
            hit_q       <= st.hit;
            evict_q     <= st.evict;
            last_q      <= !(modify_q && !fwd_q);
            hit_cnt_q   <= hit_cnt_q + CNT_W'(st.hit);
            miss_cnt_q  <= miss_cnt_q + CNT_W'(!st.hit);
            evict_cnt_q <= evict_cnt_q + CNT_W'(st.evict);
            if (modify_q && !fwd_q) begin
              fwd_q     <= 1'b1;
              fwd_row_q <= new_row;
            end else begin
              fwd_q   <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign miss_o           = !hit_q;
  assign eviction_o       = evict_q;
  assign last_o           = last_q;
  assign hit_total_o      = hit_cnt_q;
  assign miss_total_o     = miss_cnt_q;
  assign eviction_total_o = evict_cnt_q;

  // second lookup of a modify works on its own forwarded row and must hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lk_fire && fwd_q |-> st.hit)
    else $error("second lookup of a modify missed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lk_fire && st.evict |-> !st.hit)
    else $error("eviction reported on a hit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lk_fire |=> hit_total_o + miss_total_o ==
      $past(hit_total_o) + $past(miss_total_o) + CNT_W'(1))
    else $error("totals did not advance by one lookup");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(lk_fire))
    else $error("result appeared without a lookup");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> modify_q && (state_q == S_LOOK))
    else $error("row forwarding outside a modify");

endmodule
